>>> hdl/s256_pkg.sv
// Package for the SHA-256 byte stream hasher: types, round constants,
// initial hash value, sequencer states and the SHA-256 bit functions.
// Depends on nothing; the round unit, the hasher top level and the testbench use it.
`default_nettype none

package s256_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned SchedWords = 16;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastFill = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord = 3'd7;
  localparam logic [63:0] BitsPerByte = 64'd8;

  typedef logic [NumWords-1:0][WordBits-1:0] work_t;
  typedef logic [SchedWords-1:0][WordBits-1:0] sched_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_ADD  = 4'b1000
  } state_e;

  localparam work_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h428a2f98;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> hdl/s256_in_if.sv
// Input channel of the SHA-256 byte stream hasher: valid/ready handshake
// carrying one message byte with its presence and end-of-message flags.
// Depends on nothing.
`default_nettype none

interface s256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

`default_nettype wire

>>> hdl/s256_out_if.sv
// Output channel of the SHA-256 byte stream hasher: valid/ready handshake
// carrying one digest word with its index and last-word flag.
// Depends on nothing.
`default_nettype none

interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

>>> hdl/s256_round.sv
// One SHA-256 compression round and one message schedule expansion step.
// Combinational; the sequencer in the top level applies it once per cycle.
// Depends on s256_pkg.
`default_nettype none

module s256_round (
  input  var s256_pkg::work_t  work_i,
  input  var s256_pkg::sched_t sched_i,
  input  var logic [31:0]      k_i,
  output s256_pkg::work_t      work_o,
  output logic [31:0]          new_word_o
);

  logic [31:0] w_cur;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  // The window holds the oldest schedule word at the top index.
  assign w_cur = sched_i[15];

  assign new_word_o = s256_pkg::small_sigma1(sched_i[1]) + sched_i[6] +
                      s256_pkg::small_sigma0(sched_i[14]) + sched_i[15];

  assign ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
  assign maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^
               (work_i[1] & work_i[2]);
  assign t1  = work_i[7] + s256_pkg::big_sigma1(work_i[4]) + ch + k_i + w_cur;
  assign t2  = s256_pkg::big_sigma0(work_i[0]) + maj;

  always_comb begin
    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];
  end

endmodule

`default_nettype wire

>>> hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte stream hasher, at most one message byte per transaction.
// A byte that does not fill a block is stored and the unit stays idle; the byte that fills
// a block starts 64 rounds on the shared round unit and one hash add. End of message pads
// one byte per cycle, with a compression after each full block, up to the next length field,
// then loads the eight digest words, waiting while the previous digest is still draining.
// The digest sits in its own register bank, so the next message is accepted while it drains.
// Reset loads the initial hash value, clears length and fill count and empties the output.
`default_nettype none

module sha256_byte_stream_hasher_unit (
  input  var logic   clk_i,
  input  var logic   rst_ni,
  s256_in_if.sink    in_i,
  s256_out_if.source out_o
);

  s256_pkg::state_e state_q, state_d;
  logic [5:0]       fill_q, fill_d;
  logic [5:0]       rnd_q, rnd_d;
  logic [63:0]      len_q, len_d;
  logic             pad_q, pad_d;
  logic             mark_q, mark_d;
  logic             lenok_q, lenok_d;
  logic             final_q, final_d;
  logic             busy_q, busy_d;
  logic [2:0]       idx_q, idx_d;
  s256_pkg::work_t  hash_q, hash_d;
  s256_pkg::work_t  work_q, work_d;
  s256_pkg::work_t  digest_q, digest_d;
  s256_pkg::sched_t sched_q, sched_d;
  s256_pkg::work_t  work_rnd;
  logic [31:0]      new_word;
  logic [511:0]     sched_flat;
  logic             in_acc;
  logic             out_acc;
  logic             push;
  logic [7:0]       push_byte;
  logic             load_digest;

  s256_round u_round (
    .work_i     (work_q),
    .sched_i    (sched_q),
    .k_i        (s256_pkg::round_const(rnd_q)),
    .work_o     (work_rnd),
    .new_word_o (new_word)
  );

  assign in_i.ready = (state_q == s256_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign sched_flat = sched_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    len_d       = len_q;
    pad_d       = pad_q;
    mark_d      = mark_q;
    lenok_d     = lenok_q;
    final_d     = final_q;
    hash_d      = hash_q;
    work_d      = work_q;
    sched_d     = sched_q;
    push        = 1'b0;
    push_byte   = '0;
    load_digest = 1'b0;
    digest_d    = digest_q;

    unique case (state_q)
      s256_pkg::ST_IDLE: begin
        if (in_acc) begin
          lenok_d = 1'b0;
          final_d = 1'b0;
          if (in_i.byte_present) begin
            push      = 1'b1;
            push_byte = in_i.data_byte;
            len_d     = len_q + s256_pkg::BitsPerByte;
          end
          if (in_i.byte_present && fill_q == s256_pkg::LastFill) begin
            state_d = s256_pkg::ST_COMP;
            work_d  = hash_q;
            rnd_d   = '0;
            pad_d   = in_i.end_of_message;
            mark_d  = in_i.end_of_message;
          end else if (in_i.end_of_message) begin
            state_d = s256_pkg::ST_PAD;
            pad_d   = 1'b1;
            mark_d  = 1'b1;
          end
        end
      end
      s256_pkg::ST_PAD: begin
        push = 1'b1;
        if (mark_q) begin
          push_byte = s256_pkg::PadMark;
          mark_d    = 1'b0;
          lenok_d   = (fill_q < s256_pkg::LenStart);
        end else if (lenok_q && fill_q >= s256_pkg::LenStart) begin
          push_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
        end
        if (fill_q == s256_pkg::LastFill) begin
          state_d = s256_pkg::ST_COMP;
          work_d  = hash_q;
          rnd_d   = '0;
          final_d = !mark_q && lenok_q;
        end
      end
      s256_pkg::ST_COMP: begin
        work_d  = work_rnd;
        sched_d = {sched_q[14:0], new_word};
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == s256_pkg::LastRound) begin
          state_d = s256_pkg::ST_ADD;
        end
      end
      s256_pkg::ST_ADD: begin
        if (final_q) begin
          if (!busy_q) begin
            for (int i = 0; i < s256_pkg::NumWords; i++) begin
              digest_d[i] = hash_q[i] + work_q[i];
            end
            load_digest = 1'b1;
            hash_d      = s256_pkg::HashInit;
            len_d       = '0;
            pad_d       = 1'b0;
            final_d     = 1'b0;
            lenok_d     = 1'b0;
            state_d     = s256_pkg::ST_IDLE;
          end
        end else begin
          for (int i = 0; i < s256_pkg::NumWords; i++) begin
            hash_d[i] = hash_q[i] + work_q[i];
          end
          if (pad_q) begin
            lenok_d = 1'b1;
            state_d = s256_pkg::ST_PAD;
          end else begin
            state_d = s256_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = s256_pkg::ST_IDLE;
    endcase

    if (push) begin
      sched_d = {sched_flat[503:0], push_byte};
      fill_d  = fill_q + 6'd1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_digest) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (out_acc) begin
      idx_d = idx_q + 3'd1;
      if (idx_q == s256_pkg::LastWord) begin
        busy_d = 1'b0;
      end
    end
  end

  assign out_o.valid       = busy_q;
  assign out_o.digest_word = digest_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == s256_pkg::LastWord);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= s256_pkg::ST_IDLE;
      fill_q  <= '0;
      rnd_q   <= '0;
      len_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenok_q <= 1'b0;
      final_q <= 1'b0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      hash_q  <= s256_pkg::HashInit;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      len_q   <= len_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenok_q <= lenok_d;
      final_q <= final_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    sched_q  <= sched_d;
    digest_q <= digest_d;
  end

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s256_pkg::ST_COMP && rnd_q == s256_pkg::LastRound)
      |=> (state_q == s256_pkg::ST_ADD))
    else $error("compression did not end after the last round");

  a_pad_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s256_pkg::ST_PAD) |-> pad_q)
    else $error("padding without an end of message");

  a_digest_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_digest |=> (len_q == '0 && fill_q == '0 && busy_q && idx_q == '0))
    else $error("state not cleared after digest");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && idx_q == s256_pkg::LastWord) |=> !busy_q)
    else $error("output still busy after the last word");

  a_final_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s256_pkg::ST_ADD && final_q) |-> (fill_q == '0 && !mark_q))
    else $error("final block closed with a partial fill");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for sha256_byte_stream_hasher_unit, driven byte by byte.
// A scoreboard class predicts every digest word. It depends on s256_pkg, s256_in_if,
// s256_out_if and the hasher RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned RandomItems = 210;
  localparam int unsigned QuietAfter = 160;

  localparam logic [0:63][31:0] ShaRoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  class digest_scoreboard;
    logic [63:0][7:0]  block_bytes;
    logic [5:0]        fill_ptr;
    logic [63:0]       bits_done;
    logic [7:0][31:0]  chain;
    digest_word_t      digests_due[$];
    int                mismatches;
    int                bytes_taken;
    int                transactions;
    int                messages;
    int                words_checked;

    function new();
      mismatches = 0;
      bytes_taken = 0;
      transactions = 0;
      messages = 0;
      words_checked = 0;
      restart();
    endfunction

    function void restart();
      fill_ptr = '0;
      bits_done = '0;
      chain = s256_pkg::HashInit;
    endfunction

    function logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [15:0][31:0] sched;
      logic [7:0][31:0]  v;
      logic [31:0]       w2, w15, wr, t1, t2, e, a;
      int                r;
      for (r = 0; r < 16; r++) begin
        sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
      end
      v = chain;
      for (r = 0; r < 64; r++) begin
        if (r >= 16) begin
          w2 = sched[(r - 2) % 16];
          w15 = sched[(r - 15) % 16];
          sched[r % 16] = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + sched[(r - 7) % 16] +
                          (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + sched[r % 16];
        end
        wr = sched[r % 16];
        e = v[4];
        a = v[0];
        t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & v[5]) ^ (~e & v[6])) +
             ShaRoundK[r] + wr;
        t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
             ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (r = 0; r < 8; r++) begin
        chain[r] = chain[r] + v[r];
      end
    endfunction

    // Notes one accepted input transaction and queues the digest it completes, if any.
    function void take_byte(input logic [7:0] data, input logic present, input logic eom);
      int           pos;
      int           i;
      logic [63:0]  msg_bits;
      digest_word_t dw;
      transactions++;
      if (present) begin
        bytes_taken++;
        block_bytes[fill_ptr] = data;
        fill_ptr = fill_ptr + 6'd1;
        if (fill_ptr == 6'd0) begin
          compress();
          bits_done = bits_done + 64'd512;
        end
      end
      if (!eom) return;
      pos = fill_ptr;
      msg_bits = bits_done + {55'd0, fill_ptr, 3'b000};
      block_bytes[pos] = s256_pkg::PadMark;
      pos++;
      if (pos > s256_pkg::LenStart) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < s256_pkg::LenStart) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++) begin
        block_bytes[56 + i] = msg_bits[63 - 8 * i -: 8];
      end
      compress();
      for (i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.index = 3'(i);
        dw.last = (3'(i) == s256_pkg::LastWord);
        digests_due.push_back(dw);
      end
      messages++;
      restart();
    endfunction

    task report(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_digest_word(input logic [31:0] word, input logic [2:0] index, input logic last);
      digest_word_t dw;
      if (digests_due.size() == 0) begin
        report($sformatf("digest word %08h with no digest pending", word));
        return;
      end
      dw = digests_due.pop_front();
      words_checked++;
      if (word !== dw.word) begin
        report($sformatf("digest_word %08h, expected %08h", word, dw.word));
      end
      if (index !== dw.index) begin
        report($sformatf("word_index %0d, expected %0d", index, dw.index));
      end
      if (last !== dw.last) begin
        report($sformatf("last_word %0b, expected %0b", last, dw.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_stalls;
  int   stall_left;
  int   idle_cycles;
  int   random_items;

  digest_scoreboard sb;

  s256_in_if  in_ch ();
  s256_out_if out_ch ();

  sha256_byte_stream_hasher_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_left == 0 && !no_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.take_byte(in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_digest_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d cycles without a transaction", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic drive_item(input logic [7:0] data, input logic present, input logic eom);
    int gap;
    @(negedge clk_i);
    if (!no_stalls && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_present <= present;
    in_ch.end_of_message <= eom;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  // Sends one message with random bytes, now and then mixed with items that carry no byte.
  task automatic send_message(input int len);
    int  n;
    bit  end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      drive_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (n == len - 1));
      random_items++;
    end
    if (!end_on_byte) begin
      drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      random_items++;
    end
    if (random_items >= QuietAfter) no_stalls = 1'b1;
  endtask

  initial begin
    int msg_no;
    int len;
    int edge_lens [4];
    edge_lens = '{56, 55, 64, 63};
    sb = new();
    no_stalls = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    random_items = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.byte_present = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty messages, ignored bytes, idle items and byte extremes.
    drive_item(8'ha5, 1'b0, 1'b0);
    drive_item(8'hff, 1'b0, 1'b1);
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item(8'h61, 1'b1, 1'b0);
    drive_item(8'h62, 1'b1, 1'b0);
    drive_item(8'h63, 1'b1, 1'b1);
    drive_item(8'h00, 1'b1, 1'b0);
    drive_item(8'hff, 1'b1, 1'b0);
    drive_item(8'h5a, 1'b0, 1'b0);
    drive_item(8'h00, 1'b0, 1'b0);
    drive_item(8'hc3, 1'b0, 1'b1);
    drive_item(8'hff, 1'b1, 1'b1);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'h7f, 1'b0, 1'b1);

    // The sender waits here until every pending digest word has been drained.
    hold_input();
    while (sb.digests_due.size() != 0) @(posedge clk_i);

    // Random part: short messages with the padding boundary lengths mixed in.
    msg_no = 0;
    while (random_items < RandomItems) begin
      if (msg_no % 4 == 1) begin
        len = edge_lens[(msg_no / 4) % 4];
      end else begin
        len = $urandom_range(0, 12);
      end
      send_message(len);
      msg_no++;
    end

    hold_input();
    while (sb.digests_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input transactions (%0d bytes) in %0d messages.",
             sb.transactions, sb.bytes_taken, sb.messages);
    $display("%0d digest words were checked, %0d mismatches found.",
             sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/s256_pkg.sv
hdl/s256_in_if.sv
hdl/s256_out_if.sv
hdl/s256_round.sv
hdl/sha256_byte_stream_hasher_unit.sv
bench/tb_top.sv
